### rtl/core/npwr_pkg.sv
// Shared types, codes and widths for the nearest point within radius block.
package npwr_pkg;

  // Default sizes handed to the top level parameters.
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int COORD_BITS_DEF  = 32;

  // Fixed field widths of the transfers.
  localparam int HANDLE_W = 32;
  localparam int POS_W    = 32;
  localparam int RADIUS_W = 31;
  localparam int RR_W     = 2 * RADIUS_W;

  // Command codes.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // Status codes.
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FOUND = 2'd1;
  localparam logic [1:0] STATUS_NONE  = 2'd2;
  localparam logic [1:0] STATUS_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]                command;
    logic [HANDLE_W-1:0]       handle;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic [RADIUS_W-1:0]       radius;
  } npwr_req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] found_handle;
  } npwr_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } npwr_state_t;

  // Control from the sequencer into the distance pipeline.
  typedef struct packed {
    logic clear;
    logic valid;
  } npwr_scan_ctl_t;

  // Status from the distance pipeline back to the sequencer.
  typedef struct packed {
    logic active;
    logic have;
  } npwr_scan_sts_t;

endpackage

### rtl/core/nearest_point_within_radius.sv
// Nearest point within radius: point table in one RAM, walked by a distance pipeline.
// Clear, append and the unused code answer one cycle after the transfer, busy stays low,
// so such commands can follow each other every cycle.
// A query reads one entry per cycle from the RAM read port into a three-stage distance
// pipeline; its result follows the read register, stages A to C and the drain state.
// Results are strobed for one cycle, since the receiver cannot stall; synchronous reset
// empties the table and the contents of the RAM stay as they were.
module nearest_point_within_radius #(
  parameter int MAX_ENTRIES = npwr_pkg::MAX_ENTRIES_DEF,
  parameter int COORD_BITS  = npwr_pkg::COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  npwr_pkg::npwr_req_t  request,
  output logic                 done,
  output npwr_pkg::npwr_rsp_t  result
);
  import npwr_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int ENT_W = HANDLE_W + 3 * COORD_BITS;

  npwr_state_t          state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [IDX_W-1:0]     scan_idx, scan_idx_next;
  logic                 done_next;
  npwr_rsp_t            result_next;
  logic                 accept;
  logic                 issue;
  logic                 wr_en;
  logic                 load_query;
  logic                 scan_clear;
  logic                 rd_valid;
  logic [ENT_W-1:0]     rd_data;
  logic [ENT_W-1:0]     wr_data;
  logic signed [COORD_BITS-1:0] query_x, query_y, query_z;
  logic [RR_W-1:0]      radius_sq;
  npwr_scan_ctl_t       scan_ctl;
  npwr_scan_sts_t       scan_sts;
  logic [HANDLE_W-1:0]  best_handle;

  // Point table.
  logic [ENT_W-1:0] table_mem [MAX_ENTRIES];

  assign accept  = start && !busy;
  assign busy    = (state != ST_IDLE);
  assign wr_data = {request.handle, request.pos_x[COORD_BITS-1:0],
                    request.pos_y[COORD_BITS-1:0], request.pos_z[COORD_BITS-1:0]};

  // Table write on append and registered read during a scan.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[count[IDX_W-1:0]] <= wr_data;
    end
    if (issue) begin
      rd_data <= table_mem[scan_idx];
    end
  end

  // Sequencer: command decode, scan addressing and result strobe.
  always_comb begin
    state_next    = state;
    count_next    = count;
    scan_idx_next = scan_idx;
    done_next     = 1'b0;
    result_next   = '0;
    issue         = 1'b0;
    wr_en         = 1'b0;
    load_query    = 1'b0;
    scan_clear    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (request.command)
            CMD_CLEAR: begin
              count_next         = '0;
              done_next          = 1'b1;
              result_next.status = STATUS_DONE;
            end
            CMD_APPEND: begin
              done_next = 1'b1;
              if (count < CNT_W'(MAX_ENTRIES)) begin
                wr_en              = 1'b1;
                count_next         = CNT_W'(count + 1'b1);
                result_next.status = STATUS_DONE;
              end else begin
                result_next.status = STATUS_FULL;
              end
            end
            CMD_QUERY: begin
              load_query    = 1'b1;
              scan_clear    = 1'b1;
              scan_idx_next = '0;
              state_next    = (count == '0) ? ST_DRAIN : ST_SCAN;
            end
            default: begin
              done_next          = 1'b1;
              result_next.status = STATUS_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        if (CNT_W'(scan_idx) + CNT_W'(1) == count) begin
          state_next = ST_DRAIN;
        end else begin
          scan_idx_next = IDX_W'(scan_idx + 1'b1);
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !scan_sts.active) begin
          done_next   = 1'b1;
          state_next  = ST_IDLE;
          if (scan_sts.have) begin
            result_next.status       = STATUS_FOUND;
            result_next.found_handle = best_handle;
          end else begin
            result_next.status = STATUS_NONE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      done     <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      done     <= done_next;
      rd_valid <= issue;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    result   <= result_next;
    if (load_query) begin
      query_x   <= request.pos_x[COORD_BITS-1:0];
      query_y   <= request.pos_y[COORD_BITS-1:0];
      query_z   <= request.pos_z[COORD_BITS-1:0];
      radius_sq <= RR_W'(request.radius) * RR_W'(request.radius);
    end
  end

  assign scan_ctl.clear = scan_clear;
  assign scan_ctl.valid = rd_valid;

  npwr_scan #(
    .COORD_BITS(COORD_BITS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .ctl          (scan_ctl),
    .entry_handle (rd_data[ENT_W-1 -: HANDLE_W]),
    .entry_x      (rd_data[3*COORD_BITS-1 -: COORD_BITS]),
    .entry_y      (rd_data[2*COORD_BITS-1 -: COORD_BITS]),
    .entry_z      (rd_data[COORD_BITS-1:0]),
    .query_x      (query_x),
    .query_y      (query_y),
    .query_z      (query_z),
    .radius_sq    (radius_sq),
    .sts          (scan_sts),
    .best_handle  (best_handle)
  );

endmodule

### rtl/core/npwr_scan.sv
// Distance pipeline: squared distance per entry, radius test and best-so-far tracking.
module npwr_scan #(
  parameter int COORD_BITS = npwr_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  npwr_pkg::npwr_scan_ctl_t          ctl,
  input  logic [npwr_pkg::HANDLE_W-1:0]     entry_handle,
  input  logic signed [COORD_BITS-1:0]      entry_x,
  input  logic signed [COORD_BITS-1:0]      entry_y,
  input  logic signed [COORD_BITS-1:0]      entry_z,
  input  logic signed [COORD_BITS-1:0]      query_x,
  input  logic signed [COORD_BITS-1:0]      query_y,
  input  logic signed [COORD_BITS-1:0]      query_z,
  input  logic [npwr_pkg::RR_W-1:0]         radius_sq,
  output npwr_pkg::npwr_scan_sts_t          sts,
  output logic [npwr_pkg::HANDLE_W-1:0]     best_handle
);
  import npwr_pkg::*;

  localparam int MAG_W = COORD_BITS + 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int SUM_W = SQ_W + 2;
  localparam int CMP_W = (SUM_W > RR_W) ? SUM_W : RR_W;

  // Magnitude of the difference of two coordinates, exact in one extra bit.
  function automatic logic [MAG_W-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                input logic signed [COORD_BITS-1:0] b);
    logic signed [MAG_W-1:0] d;
    d = MAG_W'(a) - MAG_W'(b);
    return d[MAG_W-1] ? MAG_W'(~d + 1'b1) : MAG_W'(d);
  endfunction

  logic                va, vb, vc;
  logic [MAG_W-1:0]    mag_x, mag_y, mag_z;
  logic [SQ_W-1:0]     sq_x, sq_y, sq_z;
  logic [SUM_W-1:0]    sum_c;
  logic                qual_c;
  logic [HANDLE_W-1:0] handle_a, handle_b, handle_c;
  logic [SUM_W-1:0]    sum_comb;
  logic [SUM_W-1:0]    best_sum;
  logic                have;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      va <= ctl.valid;
      vb <= va;
      vc <= vb;
    end
  end

  // Stage A: coordinate differences.
  always_ff @(posedge clk) begin
    mag_x    <= abs_diff(query_x, entry_x);
    mag_y    <= abs_diff(query_y, entry_y);
    mag_z    <= abs_diff(query_z, entry_z);
    handle_a <= entry_handle;
  end

  // Stage B: one square per axis.
  always_ff @(posedge clk) begin
    sq_x     <= SQ_W'(mag_x) * SQ_W'(mag_x);
    sq_y     <= SQ_W'(mag_y) * SQ_W'(mag_y);
    sq_z     <= SQ_W'(mag_z) * SQ_W'(mag_z);
    handle_b <= handle_a;
  end

  // Stage C: sum of squares and strict test against the radius squared.
  assign sum_comb = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);

  always_ff @(posedge clk) begin
    sum_c    <= sum_comb;
    qual_c   <= CMP_W'(sum_comb) < CMP_W'(radius_sq);
    handle_c <= handle_b;
  end

  // Best entry so far; a strict compare keeps the earliest on ties.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      have <= 1'b0;
    end else if (vc && qual_c && (!have || sum_c < best_sum)) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vc && qual_c && (!have || sum_c < best_sum)) begin
      best_sum    <= sum_c;
      best_handle <= handle_c;
    end
  end

  assign sts.active = va | vb | vc;
  assign sts.have   = have;

endmodule

### rtl/core/npwr_check.sv
// Port-level checks for the nearest point within radius block, bound to the top level.
module npwr_check (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input npwr_pkg::npwr_req_t  request,
  input logic                 done,
  input npwr_pkg::npwr_rsp_t  result
);
  import npwr_pkg::*;

  // A result is never strobed while the block is still working.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobed while busy");

  // A transfer of anything but a query answers in the next cycle.
  a_fast_cmd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.command != CMD_QUERY) |=> done)
    else $error("non-query command did not answer in one cycle");

  // A query transfer makes the block busy and holds the result back.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && request.command == CMD_QUERY) |=> (busy && !done))
    else $error("query did not raise busy");

  // Only a found result carries a handle.
  a_handle_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STATUS_FOUND) |-> (result.found_handle == '0))
    else $error("handle set without a found status");

endmodule

bind nearest_point_within_radius npwr_check u_npwr_check (.*);
